FILE: src/rau_pkg.sv
// Shared constants for the rational arithmetic unit: operation and status codes
// and the fixed payload field widths.
// No dependencies.
`default_nettype none

package rau_pkg;

   // Payload field widths of the stream ports.
   localparam int FIELD_W = 32;
   localparam int DEN_W   = 31;
   localparam int MODE_W  = 3;
   localparam int STAT_W  = 2;

   // Operation codes; codes above MODE_DIV reduce the first fraction.
   localparam logic [MODE_W-1:0] MODE_ADD = 3'd0;
   localparam logic [MODE_W-1:0] MODE_SUB = 3'd1;
   localparam logic [MODE_W-1:0] MODE_MUL = 3'd2;
   localparam logic [MODE_W-1:0] MODE_DIV = 3'd3;

   // Result status codes.
   localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
   localparam logic [STAT_W-1:0] ST_ZDEN = 2'd1;
   localparam logic [STAT_W-1:0] ST_DIVZ = 2'd2;
   localparam logic [STAT_W-1:0] ST_OVF  = 2'd3;

endpackage

`default_nettype wire

FILE: src/rau_reduce.sv
// Reduction engine: binary gcd of numerator and denominator magnitudes, then two
// restoring divisions by the odd gcd part, all on one shared subtractor.
// Self-contained; instantiated by rational_arithmetic_unit_core.
`default_nettype none

module rau_reduce #(
   parameter int PW = 64
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [PW-1:0] num,
   input  wire logic [PW-1:0] den,
   output logic               done,
   output logic [PW-1:0]      q_num,
   output logic [PW-1:0]      q_den
);

   localparam int CW = $clog2(PW);

   typedef enum logic [4:0] {
      R_IDLE = 5'b00001,
      R_GCD  = 5'b00010,
      R_DIVN = 5'b00100,
      R_DIVD = 5'b01000,
      R_DONE = 5'b10000
   } red_state_type;

   red_state_type state_ff, state_in;
   logic [PW-1:0] x_ff, x_in, y_ff, y_in;
   logic [PW-1:0] n_ff, n_in, d_ff, d_in;
   logic [PW-1:0] rem_ff, rem_in, quo_ff, quo_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   logic [PW:0]   sub_a;
   logic [PW-1:0] sub_b;
   logic [PW+1:0] diff;
   logic          borrow;
   logic [PW-1:0] quo_shift;

   // Shared subtractor: x - y while searching the gcd, trial remainder during division.
   always_comb begin
      case (state_ff)
         R_GCD: begin
            sub_a = {1'b0, x_ff};
            sub_b = y_ff;
         end
         default: begin
            sub_a = {rem_ff, quo_ff[PW-1]};
            sub_b = x_ff;
         end
      endcase
      diff      = {1'b0, sub_a} - {2'b00, sub_b};
      borrow    = diff[PW+1];
      quo_shift = {quo_ff[PW-2:0], ~borrow};
   end

   // Sequencer and next-state values.
   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      n_in     = n_ff;
      d_in     = d_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         R_IDLE: begin
            if (start) begin
               x_in     = num;
               y_in     = den;
               n_in     = num;
               d_in     = den;
               state_in = R_GCD;
            end
         end
         R_GCD: begin
            if (y_ff == '0) begin
               // x holds the odd part of the gcd; n and d carry no common factor of two.
               quo_in   = n_ff;
               rem_in   = '0;
               cnt_in   = '0;
               state_in = R_DIVN;
            end else if (!x_ff[0] && !y_ff[0]) begin
               x_in = x_ff >> 1;
               y_in = y_ff >> 1;
               n_in = n_ff >> 1;
               d_in = d_ff >> 1;
            end else if (!x_ff[0]) begin
               x_in = x_ff >> 1;
            end else if (!y_ff[0]) begin
               y_in = y_ff >> 1;
            end else if (borrow) begin
               y_in = '0 - diff[PW-1:0];
            end else begin
               x_in = y_ff;
               y_in = diff[PW-1:0];
            end
         end
         R_DIVN, R_DIVD: begin
            rem_in = borrow ? sub_a[PW-1:0] : diff[PW-1:0];
            quo_in = quo_shift;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(PW - 1)) begin
               rem_in = '0;
               cnt_in = '0;
               if (state_ff == R_DIVN) begin
                  n_in     = quo_shift;
                  quo_in   = d_ff;
                  state_in = R_DIVD;
               end else begin
                  d_in     = quo_shift;
                  state_in = R_DONE;
               end
            end
         end
         R_DONE: begin
            state_in = R_IDLE;
         end
         default: begin
            state_in = R_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= R_IDLE;
      end else begin
         state_ff <= state_in;
      end
      x_ff   <= x_in;
      y_ff   <= y_in;
      n_ff   <= n_in;
      d_ff   <= d_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   assign done  = (state_ff == R_DONE);
   assign q_num = n_ff;
   assign q_den = d_ff;

endmodule

`default_nettype wire

FILE: src/rational_arithmetic_unit_core.sv
// Top level of the rational arithmetic unit: stream ports, operand decode, shared
// multiplier, sign combination, overflow check and result register.
// Depends on rau_pkg and rau_reduce.
//
//   Channel | Ports                        | Payload
//   --------+------------------------------+---------------------------------------
//   request | req_tvalid/tready/tdata/tuser| tdata: a_num, a_den, b_num, b_den
//           |                              | tuser: mode
//   response| rsp_tvalid/tready/tdata/tuser| tdata: res_num, res_den; tuser: status
//
// An item passes through up to three products on the shared multiplier, a binary
// gcd of one step per cycle, and two bit-serial divisions on the engine's single
// subtractor. Items in error go from idle straight to the output state.
// Reset is synchronous and clears the sequencers and the result valid flag.
// The request side is ready only when idle; a finished item waits in the result
// register while the next one is taken and worked on.
`default_nettype none

module rational_arithmetic_unit_core #(
   parameter int OPERAND_WIDTH = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [127:0] req_tdata,   // a_num[31:0], a_den[63:32], b_num[95:64],
                                          // b_den[127:96]
   input  wire logic [2:0]   req_tuser,   // mode[2:0]
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [63:0]       rsp_tdata,   // res_num[31:0], res_den[62:32], zero[63]
   output logic [1:0]        rsp_tuser    // status[1:0]
);

   localparam int W  = OPERAND_WIDTH;
   localparam int PW = 2 * OPERAND_WIDTH;
   localparam logic [PW-1:0] LIM = {{(PW-1){1'b0}}, 1'b1} << (W - 1);

   typedef enum logic [6:0] {
      S_IDLE    = 7'b0000001,
      S_PROD_P  = 7'b0000010,
      S_PROD_Q  = 7'b0000100,
      S_PROD_D  = 7'b0001000,
      S_COMBINE = 7'b0010000,
      S_REDUCE  = 7'b0100000,
      S_OUT     = 7'b1000000
   } core_state_type;

   // Sign and magnitude of the low W bits of a field.
   function automatic logic [W:0] split_fn(input logic [rau_pkg::FIELD_W-1:0] raw);
      logic [W-1:0] v;
      begin
         v        = raw[W-1:0];
         split_fn = {v[W-1], v[W-1] ? (~v + 1'b1) : v};
      end
   endfunction

   core_state_type state_ff, state_in;
   logic [rau_pkg::MODE_W-1:0] mode_ff, mode_in;
   logic an_ff, an_in, ad_ff, ad_in, bn_ff, bn_in, bd_ff, bd_in;
   logic [W-1:0] anm_ff, anm_in, adm_ff, adm_in, bnm_ff, bnm_in, bdm_ff, bdm_in;
   logic [PW-1:0] p_ff, p_in, q_ff, q_in, dm_ff, dm_in;
   logic neg_ff, neg_in;
   logic [rau_pkg::FIELD_W-1:0] fin_num_ff, fin_num_in, rsp_num_ff, rsp_num_in;
   logic [rau_pkg::DEN_W-1:0]   fin_den_ff, fin_den_in, rsp_den_ff, rsp_den_in;
   logic [rau_pkg::STAT_W-1:0]  fin_st_ff, fin_st_in, rsp_st_ff, rsp_st_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic in_an, in_ad, in_bn, in_bd;
   logic [W-1:0] in_anm, in_adm, in_bnm, in_bdm;
   logic [rau_pkg::MODE_W-1:0] in_mode;
   logic accept, out_load;

   logic is_sub, is_mul, is_div, is_addsub;
   logic [W-1:0]  mul_a, mul_b;
   logic [PW-1:0] prod;

   logic          pneg, qneg, nneg_c, dneg_c;
   logic [PW-1:0] psum;
   logic [PW:0]   pdiff;
   logic [PW-1:0] nm_c;

   logic          red_start, red_done;
   logic [PW-1:0] red_num, red_den;
   logic          ovf;
   logic [rau_pkg::FIELD_W-1:0] mag32;

   // Operand decode at the input port.
   always_comb begin
      in_mode         = req_tuser;
      {in_an, in_anm} = split_fn(req_tdata[31:0]);
      {in_ad, in_adm} = split_fn(req_tdata[63:32]);
      {in_bn, in_bnm} = split_fn(req_tdata[95:64]);
      {in_bd, in_bdm} = split_fn(req_tdata[127:96]);
   end

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_load   = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_tready);

   // Operation decode of the held item.
   always_comb begin
      is_sub    = (mode_ff == rau_pkg::MODE_SUB);
      is_mul    = (mode_ff == rau_pkg::MODE_MUL);
      is_div    = (mode_ff == rau_pkg::MODE_DIV);
      is_addsub = (mode_ff == rau_pkg::MODE_ADD) || is_sub;
   end

   // Shared multiplier: one product per cycle, registered.
   always_comb begin
      case (state_ff)
         S_PROD_P: begin
            mul_a = anm_ff;
            mul_b = is_mul ? bnm_ff : bdm_ff;
         end
         S_PROD_Q: begin
            mul_a = bnm_ff;
            mul_b = adm_ff;
         end
         default: begin
            mul_a = adm_ff;
            mul_b = is_div ? bnm_ff : bdm_ff;
         end
      endcase
      prod = {{W{1'b0}}, mul_a} * {{W{1'b0}}, mul_b};
   end

   // Signed numerator from the products, and the signs of the fraction.
   always_comb begin
      pneg  = an_ff ^ bd_ff;
      qneg  = bn_ff ^ ad_ff ^ is_sub;
      psum  = p_ff + q_ff;
      pdiff = {1'b0, p_ff} - {1'b0, q_ff};
      if (is_addsub) begin
         dneg_c = ad_ff ^ bd_ff;
         if (pneg == qneg) begin
            nm_c   = psum;
            nneg_c = pneg;
         end else if (!pdiff[PW]) begin
            nm_c   = pdiff[PW-1:0];
            nneg_c = pneg;
         end else begin
            nm_c   = '0 - pdiff[PW-1:0];
            nneg_c = qneg;
         end
      end else if (is_mul) begin
         nm_c   = p_ff;
         nneg_c = an_ff ^ bn_ff;
         dneg_c = ad_ff ^ bd_ff;
      end else if (is_div) begin
         nm_c   = p_ff;
         nneg_c = an_ff ^ bd_ff;
         dneg_c = ad_ff ^ bn_ff;
      end else begin
         nm_c   = p_ff;
         nneg_c = an_ff;
         dneg_c = ad_ff;
      end
   end

   assign red_start = (state_ff == S_COMBINE) && (nm_c != '0);

   rau_reduce #(
      .PW(PW)
   ) u_reduce (
      .clock (clock),
      .reset (reset),
      .start (red_start),
      .num   (nm_c),
      .den   (dm_ff),
      .done  (red_done),
      .q_num (red_num),
      .q_den (red_den)
   );

   // Range check and magnitude of the reduced fraction.
   always_comb begin
      ovf   = (red_den >= LIM) || (neg_ff ? (red_num > LIM) : (red_num >= LIM));
      mag32 = rau_pkg::FIELD_W'(red_num[W-1:0]);
   end

   // Sequencer.
   always_comb begin
      state_in   = state_ff;
      mode_in    = mode_ff;
      an_in      = an_ff;
      ad_in      = ad_ff;
      bn_in      = bn_ff;
      bd_in      = bd_ff;
      anm_in     = anm_ff;
      adm_in     = adm_ff;
      bnm_in     = bnm_ff;
      bdm_in     = bdm_ff;
      p_in       = p_ff;
      q_in       = q_ff;
      dm_in      = dm_ff;
      neg_in     = neg_ff;
      fin_num_in = fin_num_ff;
      fin_den_in = fin_den_ff;
      fin_st_in  = fin_st_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               mode_in    = in_mode;
               {an_in, ad_in, bn_in, bd_in} = {in_an, in_ad, in_bn, in_bd};
               {anm_in, adm_in, bnm_in, bdm_in} = {in_anm, in_adm, in_bnm, in_bdm};
               p_in       = {{W{1'b0}}, in_anm};
               dm_in      = {{W{1'b0}}, in_adm};
               fin_num_in = '0;
               fin_den_in = rau_pkg::DEN_W'(1);
               if (in_adm == '0 || (in_mode <= rau_pkg::MODE_DIV && in_bdm == '0)) begin
                  fin_st_in = rau_pkg::ST_ZDEN;
                  state_in  = S_OUT;
               end else if (in_mode == rau_pkg::MODE_DIV && in_bnm == '0) begin
                  fin_st_in = rau_pkg::ST_DIVZ;
                  state_in  = S_OUT;
               end else if (in_mode > rau_pkg::MODE_DIV) begin
                  state_in = S_COMBINE;
               end else begin
                  state_in = S_PROD_P;
               end
            end
         end
         S_PROD_P: begin
            p_in     = prod;
            state_in = is_addsub ? S_PROD_Q : S_PROD_D;
         end
         S_PROD_Q: begin
            q_in     = prod;
            state_in = S_PROD_D;
         end
         S_PROD_D: begin
            dm_in    = prod;
            state_in = S_COMBINE;
         end
         S_COMBINE: begin
            neg_in = nneg_c ^ dneg_c;
            if (nm_c == '0) begin
               // A zero result comes out as 0/1.
               fin_num_in = '0;
               fin_den_in = rau_pkg::DEN_W'(1);
               fin_st_in  = rau_pkg::ST_OK;
               state_in   = S_OUT;
            end else begin
               state_in = S_REDUCE;
            end
         end
         S_REDUCE: begin
            if (red_done) begin
               if (ovf) begin
                  fin_num_in = '0;
                  fin_den_in = rau_pkg::DEN_W'(1);
                  fin_st_in  = rau_pkg::ST_OVF;
               end else begin
                  fin_num_in = neg_ff ? ('0 - mag32) : mag32;
                  fin_den_in = rau_pkg::DEN_W'(red_den[W-2:0]);
                  fin_st_in  = rau_pkg::ST_OK;
               end
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Result register toward the response side.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_num_in   = rsp_num_ff;
      rsp_den_in   = rsp_den_ff;
      rsp_st_in    = rsp_st_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_num_in   = fin_num_ff;
         rsp_den_in   = fin_den_ff;
         rsp_st_in    = fin_st_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff    <= mode_in;
      an_ff      <= an_in;
      ad_ff      <= ad_in;
      bn_ff      <= bn_in;
      bd_ff      <= bd_in;
      anm_ff     <= anm_in;
      adm_ff     <= adm_in;
      bnm_ff     <= bnm_in;
      bdm_ff     <= bdm_in;
      p_ff       <= p_in;
      q_ff       <= q_in;
      dm_ff      <= dm_in;
      neg_ff     <= neg_in;
      fin_num_ff <= fin_num_in;
      fin_den_ff <= fin_den_in;
      fin_st_ff  <= fin_st_in;
      rsp_num_ff <= rsp_num_in;
      rsp_den_ff <= rsp_den_in;
      rsp_st_ff  <= rsp_st_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_den_ff, rsp_num_ff};
   assign rsp_tuser  = rsp_st_ff;

endmodule

`default_nettype wire

FILE: test/testbench.sv
// Self-checking testbench for rational_arithmetic_unit_core: directed and random items
// with random idling on both stream sides, checked against a built-in fraction predictor.
// Depends on rau_pkg and the RTL of the rational arithmetic unit.
`default_nettype none

module testbench;

   localparam int CLOCK_PERIOD   = 20;
   localparam int RESET_CYCLES   = 10;
   localparam int MAX_IDLE       = 14;
   localparam int DRAIN_CYCLES   = 450;
   localparam int TIMEOUT_CYCLES = 2_500_000;
   localparam int RANDOM_ITEMS   = 1050;
   localparam int PHASE_ITEMS    = 75;

   // Mode codes that the package does not name.
   localparam logic [rau_pkg::MODE_W-1:0] MODE_REDUCE = 3'd4;
   localparam logic [rau_pkg::MODE_W-1:0] MODE_LAST   = {rau_pkg::MODE_W{1'b1}};

   localparam logic [rau_pkg::FIELD_W-1:0] MIN_VAL = 32'h8000_0000;
   localparam logic [rau_pkg::FIELD_W-1:0] MAX_VAL = 32'h7FFF_FFFF;

   typedef struct packed {
      logic [rau_pkg::FIELD_W-1:0] num;
      logic [rau_pkg::DEN_W-1:0]   den;
      logic [rau_pkg::STAT_W-1:0]  status;
   } fraction_type;

   typedef enum int {OPK_SMALL, OPK_MEDIUM, OPK_WIDE, OPK_EDGE} operand_kind_type;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata  = '0;
   logic [2:0]   req_tuser  = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [63:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;

   fraction_type expected_fractions[$];
   int           error_count = 0;
   bit           req_no_idle = 1'b0;
   bit           rsp_no_idle = 1'b0;
   int           rsp_stall_left = 0;

   rational_arithmetic_unit_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Magnitude of a two's complement operand; the most negative value gives 2^31.
   function automatic bit [63:0] magnitude_of(input logic [rau_pkg::FIELD_W-1:0] v);
      if (v[rau_pkg::FIELD_W-1]) begin
         return (64'd1 << rau_pkg::FIELD_W) - 64'(v);
      end
      return 64'(v);
   endfunction

   // Exact sign-magnitude arithmetic followed by Euclid reduction and range check.
   function automatic fraction_type predict_fraction(
         input logic [rau_pkg::MODE_W-1:0]  mode,
         input logic [rau_pkg::FIELD_W-1:0] an_raw,
         input logic [rau_pkg::FIELD_W-1:0] ad_raw,
         input logic [rau_pkg::FIELD_W-1:0] bn_raw,
         input logic [rau_pkg::FIELD_W-1:0] bd_raw);
      bit           an_neg, ad_neg, bn_neg, bd_neg;
      bit           p_neg, q_neg, n_neg, d_neg, r_neg, two_op;
      bit [63:0]    an_mag, ad_mag, bn_mag, bd_mag;
      bit [63:0]    p_mag, q_mag, n_mag, d_mag, x, y, t, limit;
      fraction_type r;
      r.num    = '0;
      r.den    = 31'd1;
      r.status = rau_pkg::ST_OK;
      two_op = (mode <= rau_pkg::MODE_DIV);
      an_neg = an_raw[rau_pkg::FIELD_W-1];
      ad_neg = ad_raw[rau_pkg::FIELD_W-1];
      bn_neg = bn_raw[rau_pkg::FIELD_W-1];
      bd_neg = bd_raw[rau_pkg::FIELD_W-1];
      an_mag = magnitude_of(an_raw);
      ad_mag = magnitude_of(ad_raw);
      bn_mag = magnitude_of(bn_raw);
      bd_mag = magnitude_of(bd_raw);

      // Zero denominator takes priority over division by a zero fraction.
      if (ad_mag == 0 || (two_op && bd_mag == 0)) begin
         r.status = rau_pkg::ST_ZDEN;
         return r;
      end
      if (mode == rau_pkg::MODE_DIV && bn_mag == 0) begin
         r.status = rau_pkg::ST_DIVZ;
         return r;
      end

      case (mode)
         rau_pkg::MODE_ADD, rau_pkg::MODE_SUB: begin
            p_neg = an_neg != bd_neg;
            p_mag = an_mag * bd_mag;
            q_neg = bn_neg != ad_neg;
            q_mag = bn_mag * ad_mag;
            if (mode == rau_pkg::MODE_SUB) begin
               q_neg = !q_neg;
            end
            if (p_neg == q_neg) begin
               n_neg = p_neg;
               n_mag = p_mag + q_mag;
            end else if (p_mag >= q_mag) begin
               n_neg = p_neg;
               n_mag = p_mag - q_mag;
            end else begin
               n_neg = q_neg;
               n_mag = q_mag - p_mag;
            end
            d_neg = ad_neg != bd_neg;
            d_mag = ad_mag * bd_mag;
         end
         rau_pkg::MODE_MUL: begin
            n_neg = an_neg != bn_neg;
            n_mag = an_mag * bn_mag;
            d_neg = ad_neg != bd_neg;
            d_mag = ad_mag * bd_mag;
         end
         rau_pkg::MODE_DIV: begin
            n_neg = an_neg != bd_neg;
            n_mag = an_mag * bd_mag;
            d_neg = ad_neg != bn_neg;
            d_mag = ad_mag * bn_mag;
         end
         default: begin
            n_neg = an_neg;
            n_mag = an_mag;
            d_neg = ad_neg;
            d_mag = ad_mag;
         end
      endcase

      // A zero numerator always comes out as 0/1.
      if (n_mag == 0) begin
         return r;
      end

      x = n_mag;
      y = d_mag;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      n_mag = n_mag / x;
      d_mag = d_mag / x;

      r_neg = n_neg != d_neg;
      limit = 64'd1 << (rau_pkg::FIELD_W - 1);
      if (d_mag > limit - 1 || n_mag > (r_neg ? limit : limit - 1)) begin
         r.status = rau_pkg::ST_OVF;
         return r;
      end
      r.num = r_neg ? rau_pkg::FIELD_W'(-n_mag) : rau_pkg::FIELD_W'(n_mag);
      r.den = rau_pkg::DEN_W'(d_mag);
      return r;
   endfunction

   function automatic int draw_idle(input bit no_idle);
      return no_idle ? 0 : $urandom_range(0, MAX_IDLE);
   endfunction

   // Sends one item after a random gap and records its expected result on acceptance.
   // The valid flag is only lowered when a gap follows, so it never toggles within a step.
   task automatic send_item(input logic [rau_pkg::MODE_W-1:0]  mode,
                            input logic [rau_pkg::FIELD_W-1:0] a_num,
                            input logic [rau_pkg::FIELD_W-1:0] a_den,
                            input logic [rau_pkg::FIELD_W-1:0] b_num,
                            input logic [rau_pkg::FIELD_W-1:0] b_den);
      int gap;
      gap = draw_idle(req_no_idle);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {b_den, b_num, a_den, a_num};
      req_tuser  <= mode;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      expected_fractions.push_back(predict_fraction(mode, a_num, a_den, b_num, b_den));
   endtask

   // Result side: random stall before each item, then compare with the oldest expectation.
   always @(posedge clock) begin
      fraction_type want;
      if (reset) begin
         rsp_tready     <= 1'b0;
         rsp_stall_left  = draw_idle(rsp_no_idle);
      end else if (rsp_tready && rsp_tvalid) begin
         if (expected_fractions.size() == 0) begin
            $error("unexpected result: tdata %h, tuser %0d", rsp_tdata, rsp_tuser);
            error_count++;
         end else begin
            want = expected_fractions.pop_front();
            if (rsp_tdata[31:0] !== want.num) begin
               $error("res_num: expected %0d, actual %0d",
                      $signed(want.num), $signed(rsp_tdata[31:0]));
               error_count++;
            end
            if (rsp_tdata[62:32] !== want.den) begin
               $error("res_den: expected %0d, actual %0d", want.den, rsp_tdata[62:32]);
               error_count++;
            end
            if (rsp_tdata[63] !== 1'b0) begin
               $error("padding: expected 0, actual %b", rsp_tdata[63]);
               error_count++;
            end
            if (rsp_tuser !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_tuser);
               error_count++;
            end
         end
         rsp_stall_left = draw_idle(rsp_no_idle);
         if (rsp_stall_left != 0) begin
            rsp_tready <= 1'b0;
         end
      end else if (!rsp_tready) begin
         if (rsp_stall_left == 0) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_stall_left--;
         end
      end
   end

   // Draws one operand of the given kind.
   function automatic logic [rau_pkg::FIELD_W-1:0] draw_operand(
         input operand_kind_type kind);
      logic [rau_pkg::FIELD_W-1:0] v;
      case (kind)
         OPK_SMALL:  v = int'($urandom_range(0, 2000)) - 1000;
         OPK_MEDIUM: v = int'($urandom_range(0, 65535)) - 32768;
         OPK_WIDE:   v = $urandom;
         default: begin
            case ($urandom_range(0, 5))
               0:       v = '0;
               1:       v = 32'd1;
               2:       v = '1;
               3:       v = MAX_VAL;
               4:       v = MIN_VAL;
               default: v = $urandom;
            endcase
         end
      endcase
      return v;
   endfunction

   // Every operation on plain fractions, unused modes acting as reduce.
   task automatic test_each_mode();
      send_item(rau_pkg::MODE_ADD, 1, 2, 1, 3);
      send_item(rau_pkg::MODE_SUB, 1, 2, 1, 3);
      send_item(rau_pkg::MODE_MUL, -2, 3, 3, 4);
      send_item(rau_pkg::MODE_DIV, 1, 2, -1, 4);
      send_item(MODE_REDUCE, 6, -8, 5, 7);
      send_item(MODE_REDUCE + 3'd1, -9, 12, 0, 0);
      send_item(MODE_REDUCE + 3'd2, 14, -21, 3, 0);
      send_item(MODE_LAST, 0, -5, 0, 0);
   endtask

   // Zero denominators and division by a zero fraction, including their priority.
   task automatic test_error_cases();
      send_item(rau_pkg::MODE_ADD, 3, 0, 1, 2);
      send_item(rau_pkg::MODE_MUL, 3, 4, 1, 0);
      send_item(rau_pkg::MODE_DIV, 3, 4, 0, 5);
      send_item(rau_pkg::MODE_DIV, 3, 4, 0, 0);
      send_item(MODE_REDUCE, 7, 0, 1, 1);
   endtask

   // Extreme operand values and results at the edge of the 32-bit range.
   task automatic test_field_extremes();
      send_item(MODE_REDUCE, MIN_VAL, 1, 0, 0);
      send_item(MODE_REDUCE, MIN_VAL, -1, 0, 0);
      send_item(MODE_REDUCE, 1, MIN_VAL, 0, 0);
      send_item(MODE_REDUCE, MAX_VAL, MIN_VAL, 0, 0);
      send_item(MODE_REDUCE, MIN_VAL, MIN_VAL, 0, 0);
      send_item(rau_pkg::MODE_MUL, MAX_VAL, 1, MAX_VAL, 1);
      send_item(rau_pkg::MODE_MUL, MIN_VAL, 1, -1, 1);
      send_item(rau_pkg::MODE_SUB, MAX_VAL, MIN_VAL, MAX_VAL, MIN_VAL);
      send_item(rau_pkg::MODE_DIV, MIN_VAL, MAX_VAL, MIN_VAL, MAX_VAL);
      send_item(rau_pkg::MODE_ADD, -1, -1, MAX_VAL, 1);
      send_item(rau_pkg::MODE_ADD, MIN_VAL, MAX_VAL, MIN_VAL, MAX_VAL);
   endtask

   // Mostly well-formed fractions with shared factors, some wide and edge values,
   // and some malformed items; idling is switched off for whole phases at random.
   task automatic test_random_mix(input int count);
      logic [rau_pkg::MODE_W-1:0]  mode;
      logic [rau_pkg::FIELD_W-1:0] an, ad, bn, bd;
      operand_kind_type            kind;
      int                          sel, factor;
      for (int i = 0; i < count; i++) begin
         if (i % PHASE_ITEMS == 0) begin
            req_no_idle = ($urandom_range(0, 3) == 0);
            rsp_no_idle = ($urandom_range(0, 3) == 0);
         end
         sel  = $urandom_range(0, 99);
         mode = rau_pkg::MODE_W'($urandom_range(rau_pkg::MODE_ADD, MODE_REDUCE));
         kind = (sel < 55) ? OPK_SMALL : (sel < 70) ? OPK_MEDIUM :
                (sel < 85) ? OPK_WIDE : OPK_EDGE;
         an = draw_operand(kind);
         ad = draw_operand(kind);
         bn = draw_operand(kind);
         bd = draw_operand(kind);
         if (kind == OPK_EDGE) begin
            mode = rau_pkg::MODE_W'($urandom_range(rau_pkg::MODE_ADD, MODE_LAST));
         end
         if (sel < 70) begin
            // Well-formed: nonzero denominators; small operands are also scaled by a common factor.
            if (ad == 0) ad = 1;
            if (bd == 0) bd = 1;
            if (kind == OPK_SMALL) begin
               factor = $urandom_range(1, 40);
               an = an * factor;
               ad = ad * factor;
               factor = $urandom_range(1, 40);
               bn = bn * factor;
               bd = bd * factor;
            end
         end else if (sel >= 93) begin
            // Malformed or ignored items built on small operands and a wide b_num.
            an = draw_operand(OPK_SMALL);
            ad = draw_operand(OPK_SMALL);
            bn = draw_operand(OPK_WIDE);
            bd = draw_operand(OPK_SMALL);
            sel = $urandom_range(0, 3);
            if (sel == 0) begin
               mode = rau_pkg::MODE_W'($urandom_range(MODE_REDUCE + 3'd1, MODE_LAST));
               bd   = $urandom_range(0, 1) ? '0 : bd;
            end else if (sel == 1) begin
               ad = '0;
            end else if (sel == 2) begin
               bd = '0;
            end else begin
               mode = rau_pkg::MODE_DIV;
               bn   = '0;
            end
         end
         send_item(mode, an, ad, bn, bd);
      end
   endtask

   // Run limit, far above the slowest legal run.
   initial begin
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_each_mode();
      test_error_cases();
      test_field_extremes();
      test_random_mix(RANDOM_ITEMS);

      // Drain: wait for every expected item, then keep watching for strays.
      req_tvalid  <= 1'b0;
      rsp_no_idle  = 1'b0;
      while (expected_fractions.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
